// ===== rtl/core/cdbd_pkg.sv =====
// Shared types and constants for the calendar day counter.
// Used by cdbd_cal_unit, cdbd_seq and calendar_days_between_dates_core.
`default_nettype none

package cdbd_pkg;

    // field widths fixed by the date format
    localparam int DAY_BITS   = 5;
    localparam int MONTH_BITS = 4;

    // the Gregorian cycle repeats every 400 years
    localparam int CYCLE_YEARS = 400;
    localparam int Y400_BITS   = 9;

    // month codes used by the calendar logic
    localparam logic [MONTH_BITS-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_BITS-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_BITS-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_BITS-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_BITS-1:0] MONTH_MAY = 4'd5;
    localparam logic [MONTH_BITS-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_BITS-1:0] MONTH_JUL = 4'd7;
    localparam logic [MONTH_BITS-1:0] MONTH_AUG = 4'd8;
    localparam logic [MONTH_BITS-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_BITS-1:0] MONTH_OCT = 4'd10;
    localparam logic [MONTH_BITS-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_BITS-1:0] MONTH_DEC = 4'd12;

    // month lengths
    localparam logic [DAY_BITS-1:0] LEN_LONG  = 5'd31;
    localparam logic [DAY_BITS-1:0] LEN_SHORT = 5'd30;
    localparam logic [DAY_BITS-1:0] LEN_FEB   = 5'd28;
    localparam logic [DAY_BITS-1:0] LEN_FEB_L = 5'd29;
    localparam logic [DAY_BITS-1:0] LEN_NONE  = 5'd0;

    // century-year positions within the 400-year cycle, and its last position
    localparam logic [Y400_BITS-1:0] Y400_C1   = 9'd100;
    localparam logic [Y400_BITS-1:0] Y400_C2   = 9'd200;
    localparam logic [Y400_BITS-1:0] Y400_C3   = 9'd300;
    localparam logic [Y400_BITS-1:0] Y400_LAST = 9'd399;

    // sequencer states
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RED_S = 7'b0000010,
        S_RED_E = 7'b0000100,
        S_CHK_S = 7'b0001000,
        S_CHK_E = 7'b0010000,
        S_WALK  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    // result of the calendar unit for one date
    typedef struct packed {
        logic                  valid;
        logic [DAY_BITS-1:0]   day_next;
        logic [MONTH_BITS-1:0] month_next;
        logic                  year_inc;
        logic [Y400_BITS-1:0]  y400_next;
    } t_cal_res;

    // status from the sequencer to the top level
    typedef struct packed {
        logic idle;
        logic done;
        logic invalid;
    } t_seq_stat;

endpackage

`default_nettype wire

// ===== rtl/core/cdbd_cal_unit.sv =====
// Calendar unit: month length, date check and one-day advance of a date.
// Depends on cdbd_pkg; the year is given as its position in the 400-year cycle.
`default_nettype none

module cdbd_cal_unit
    import cdbd_pkg::*;
(
    input  wire logic [DAY_BITS-1:0]   i_day,
    input  wire logic [MONTH_BITS-1:0] i_month,
    input  wire logic [Y400_BITS-1:0]  i_y400,
    output t_cal_res                   o_res
);

    logic                leap;
    logic [DAY_BITS-1:0] month_len;

    // divisible by 4, and not a century unless divisible by 400
    assign leap = (i_y400[1:0] == 2'b00) &&
                  (i_y400 != Y400_C1) && (i_y400 != Y400_C2) && (i_y400 != Y400_C3);

    // month length, zero for a month code outside the year
    always_comb begin
        case (i_month)
            MONTH_FEB: month_len = leap ? LEN_FEB_L : LEN_FEB;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: month_len = LEN_SHORT;
            MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL, MONTH_AUG, MONTH_OCT,
            MONTH_DEC: month_len = LEN_LONG;
            default: month_len = LEN_NONE;
        endcase
    end

    // date check and next day
    always_comb begin
        o_res.valid      = (month_len != LEN_NONE) && (i_day != '0) && (i_day <= month_len);
        o_res.day_next   = i_day + DAY_BITS'(1);
        o_res.month_next = i_month;
        o_res.year_inc   = 1'b0;
        o_res.y400_next  = i_y400;
        if (i_day >= month_len) begin
            o_res.day_next = DAY_BITS'(1);
            if (i_month == MONTH_DEC) begin
                o_res.month_next = MONTH_JAN;
                o_res.year_inc   = 1'b1;
                o_res.y400_next  = (i_y400 == Y400_LAST) ? '0 : i_y400 + Y400_BITS'(1);
            end else begin
                o_res.month_next = i_month + MONTH_BITS'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/cdbd_seq.sv =====
// Sequencer and working registers: year reduction, date checks, day walk.
// Depends on cdbd_pkg and drives one shared cdbd_cal_unit.
`default_nettype none

module cdbd_seq
    import cdbd_pkg::*;
#(
    parameter int COUNT_BITS = 22,
    parameter int YEAR_BITS  = 14
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DAY_BITS-1:0]   i_start_day,
    input  wire logic [MONTH_BITS-1:0] i_start_month,
    input  wire logic [YEAR_BITS-1:0]  i_start_year,
    input  wire logic [DAY_BITS-1:0]   i_end_day,
    input  wire logic [MONTH_BITS-1:0] i_end_month,
    input  wire logic [YEAR_BITS-1:0]  i_end_year,
    input  wire logic                  i_include_end,
    input  wire logic                  i_out_free,
    output t_seq_stat                  o_stat,
    output logic [COUNT_BITS-1:0]      o_count
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [YEAR_BITS-1:0]  CYCLE_Y   = YEAR_BITS'(CYCLE_YEARS);

    t_state                r_state, n_state;
    logic [DAY_BITS-1:0]   r_day, n_day, r_eday, n_eday;
    logic [MONTH_BITS-1:0] r_month, n_month, r_emonth, n_emonth;
    logic [YEAR_BITS-1:0]  r_year, n_year, r_eyear, n_eyear;
    logic [YEAR_BITS-1:0]  r_rem, n_rem;
    logic [Y400_BITS-1:0]  r_y400, n_y400, r_ey400, n_ey400;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  r_inval, n_inval;

    logic [DAY_BITS-1:0]   u_day;
    logic [MONTH_BITS-1:0] u_month;
    logic [Y400_BITS-1:0]  u_y400;
    t_cal_res              cal;
    logic                  before_end;
    logic                  rem_big;

    // the calendar unit sees the end date only while it is being checked
    assign u_day   = (r_state == S_CHK_E) ? r_eday   : r_day;
    assign u_month = (r_state == S_CHK_E) ? r_emonth : r_month;
    assign u_y400  = (r_state == S_CHK_E) ? r_ey400  : r_y400;

    cdbd_cal_unit u_cal (
        .i_day   (u_day),
        .i_month (u_month),
        .i_y400  (u_y400),
        .o_res   (cal)
    );

    // working date strictly before the end date
    assign before_end = {r_year, r_month, r_day} < {r_eyear, r_emonth, r_eday};
    assign rem_big    = r_rem >= CYCLE_Y;

    // next-state and datapath
    always_comb begin
        n_state  = r_state;
        n_day    = r_day;
        n_month  = r_month;
        n_year   = r_year;
        n_eday   = r_eday;
        n_emonth = r_emonth;
        n_eyear  = r_eyear;
        n_rem    = r_rem;
        n_y400   = r_y400;
        n_ey400  = r_ey400;
        n_count  = r_count;
        n_inval  = r_inval;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_day    = i_start_day;
                    n_month  = i_start_month;
                    n_year   = i_start_year;
                    n_eday   = i_end_day;
                    n_emonth = i_end_month;
                    n_eyear  = i_end_year;
                    n_rem    = i_start_year;
                    n_count  = '0;
                    n_inval  = 1'b0;
                    n_state  = S_RED_S;
                end
            end
            S_RED_S: begin
                if (rem_big) begin
                    n_rem = r_rem - CYCLE_Y;
                end else begin
                    n_y400  = r_rem[Y400_BITS-1:0];
                    n_rem   = r_eyear;
                    n_state = S_RED_E;
                end
            end
            S_RED_E: begin
                if (rem_big) begin
                    n_rem = r_rem - CYCLE_Y;
                end else begin
                    n_ey400 = r_rem[Y400_BITS-1:0];
                    n_state = S_CHK_S;
                end
            end
            S_CHK_S: begin
                n_inval = !cal.valid;
                n_state = S_CHK_E;
            end
            S_CHK_E: begin
                if (r_inval || !cal.valid) begin
                    n_inval = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (!before_end || (r_count == COUNT_MAX)) begin
                    n_state = S_DONE;
                end else begin
                    n_day   = cal.day_next;
                    n_month = cal.month_next;
                    n_y400  = cal.y400_next;
                    n_year  = cal.year_inc ? r_year + YEAR_BITS'(1) : r_year;
                    n_count = r_count + COUNT_BITS'(1);
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_inval <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_inval <= n_inval;
        end
    end

    // working date registers
    always_ff @(posedge i_clk) begin
        r_day    <= n_day;
        r_month  <= n_month;
        r_year   <= n_year;
        r_eday   <= n_eday;
        r_emonth <= n_emonth;
        r_eyear  <= n_eyear;
        r_rem    <= n_rem;
        r_y400   <= n_y400;
        r_ey400  <= n_ey400;
    end

    // result word: zero for an invalid date, else with the end day added and saturated
    always_comb begin
        if (r_inval) begin
            o_count = '0;
        end else if (i_include_end && (r_count != COUNT_MAX)) begin
            o_count = r_count + COUNT_BITS'(1);
        end else begin
            o_count = r_count;
        end
    end

    assign o_stat.idle    = (r_state == S_IDLE);
    assign o_stat.done    = (r_state == S_DONE) && i_out_free;
    assign o_stat.invalid = r_inval;

`ifndef SYNTHESIS
    // each walk cycle advances the count by exactly one day
    a_walk_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) && $past(r_state == S_WALK) |->
        r_count == $past(r_count) + COUNT_BITS'(1))
        else $error("walk count did not advance by one");

    // the cycle position stays inside the 400-year cycle while walking
    a_y400_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_y400 < Y400_BITS'(CYCLE_YEARS)))
        else $error("year cycle position out of range");

    // an invalid date always reports a zero count
    a_inval_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.done && o_stat.invalid |-> (o_count == '0))
        else $error("invalid date with nonzero count");

    // the walk only runs on checked dates with a real month
    a_walk_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_month >= MONTH_JAN) && (r_month <= MONTH_DEC) && !r_inval)
        else $error("walking an unchecked date");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/calendar_days_between_dates_core.sv =====
// Top level of the calendar day counter: handshakes, config register, result word.
// Depends on cdbd_pkg, cdbd_seq and cdbd_cal_unit.
`default_nettype none

// Counts the days from a start date to an end date in the Gregorian calendar
// by stepping a working date forward one day per clock. An item first
// reduces the start year and then the end year into the 400-year leap
// cycle with one subtract per cycle, then checks the start date and then
// the end date, and then walks: the single calendar unit advances the date
// once per cycle, and a final step sees the end. The walked day count,
// before the end day is added, is zero when the end is not after the start
// and is capped at the count's full scale; an invalid date skips the walk.
// The next word is taken in the cycle after the result is loaded.
// o_in_stall is high from the accepted word until its result is handed to
// the output register, which can still hold the previous result while the
// next word is being worked on; a finished result waits, and the input
// stays stalled, while that register holds a word that is not yet taken.
// Invalid months or days give input_invalid with a zero count; the count
// saturates at its maximum, also after the optional end day is added.
module calendar_days_between_dates_core
    import cdbd_pkg::*;
#(
    parameter int COUNT_BITS = 22,
    parameter int YEAR_BITS  = 14
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input word
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [DAY_BITS-1:0]   i_start_day,
    input  wire logic [MONTH_BITS-1:0] i_start_month,
    input  wire logic [YEAR_BITS-1:0]  i_start_year,
    input  wire logic [DAY_BITS-1:0]   i_end_day,
    input  wire logic [MONTH_BITS-1:0] i_end_month,
    input  wire logic [YEAR_BITS-1:0]  i_end_year,
    // result word
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [COUNT_BITS-1:0]      o_day_count,
    output logic                       o_input_invalid,
    // config write
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic                  i_cfg_data
);

    t_seq_stat             stat;
    logic [COUNT_BITS-1:0] seq_count;
    logic                  start;
    logic                  out_free;
    logic                  r_include, r_out_valid;
    logic [COUNT_BITS-1:0] r_count;
    logic                  r_inval;

    assign o_in_stall  = !stat.idle;
    assign start       = i_in_valid && stat.idle;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    cdbd_seq #(
        .COUNT_BITS (COUNT_BITS),
        .YEAR_BITS  (YEAR_BITS)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_start_day   (i_start_day),
        .i_start_month (i_start_month),
        .i_start_year  (i_start_year),
        .i_end_day     (i_end_day),
        .i_end_month   (i_end_month),
        .i_end_year    (i_end_year),
        .i_include_end (r_include),
        .i_out_free    (out_free),
        .o_stat        (stat),
        .o_count       (seq_count)
    );

    // config register and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_include   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_include <= i_cfg_data;
            end
            if (stat.done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (stat.done) begin
            r_count <= seq_count;
            r_inval <= stat.invalid;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_day_count     = r_count;
    assign o_input_invalid = r_inval;

endmodule

`default_nettype wire
